>>> sv/steerable_filter_max_response_assert.svh
// Assertion macros used by the checker file of the steerable filter block.
`ifndef STEERABLE_FILTER_MAX_RESPONSE_ASSERT_SVH
`define STEERABLE_FILTER_MAX_RESPONSE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SMFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smfr assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SMFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smfr assertion failed");

`endif

>>> sv/smfr_pkg.sv
// Types and constants shared by the steerable filter front, back and top level.
package smfr_pkg;

  localparam int RESP_W      = 32;
  localparam int DIR_W       = 18;
  localparam int ENTRY_W     = 9;
  localparam int COUNT_W     = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int NUM_TERMS   = 6;
  localparam int PROD_W      = 2 * DIR_W;
  localparam int WGT_W       = 30;
  localparam int ACC_W       = 66;
  localparam int RND_SHIFT   = 24;
  localparam int NUM_STAGES  = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [DIR_W-1:0] UNIT_X     = 18'sd65536;
  localparam logic [31:0]             DIV3_RECIP = 32'hAAAAAAAB;
  localparam logic [31:0]             DIV3_BIAS  = 32'hC0000000;
  localparam logic [31:0]             DIV3_UNBIAS = 32'h40000000;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_PROCESS = 1'b1
  } cmd_e;

  typedef enum logic {
    MODE_WALL     = 1'b0,
    MODE_FILAMENT = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_MODE     = 2'd0,
    REG_DIRECTION_COUNT = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } back_state_e;

  typedef logic signed [RESP_W-1:0] resp_t;
  typedef resp_t [NUM_TERMS-1:0]    resp_vec_t;

  typedef struct packed {
    logic                     we;
    logic [ENTRY_W-1:0]       idx;
    logic signed [DIR_W-1:0]  x;
    logic signed [DIR_W-1:0]  y;
    logic signed [DIR_W-1:0]  z;
  } load_req_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_status_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tag_t;

endpackage

>>> sv/smfr_front.sv
// Front end: accepts items, routes table loads and queues voxel work for the back end.
module smfr_front #(
  parameter int MAX_DIRECTIONS = 512
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 command_i,
  input  logic [smfr_pkg::ENTRY_W-1:0]         entry_index_i,
  input  logic signed [smfr_pkg::DIR_W-1:0]    dir_x_i,
  input  logic signed [smfr_pkg::DIR_W-1:0]    dir_y_i,
  input  logic signed [smfr_pkg::DIR_W-1:0]    dir_z_i,
  input  smfr_pkg::resp_vec_t                  resp_i,
  output smfr_pkg::load_req_t                  load_o,
  output logic                                 q_valid_o,
  output smfr_pkg::resp_vec_t                  q_resp_o,
  input  smfr_pkg::back_status_t               status_i
);
  import smfr_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  resp_vec_t          ent_q [QUEUE_DEPTH];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               is_proc, accept, push;

  // Loads wait until no voxel is queued or running so each voxel sees the table as of its turn.
  assign is_proc    = (command_i == CMD_PROCESS);
  assign in_ready_o = is_proc ? (cnt_q != CNT_W'(QUEUE_DEPTH)) : ((cnt_q == '0) && !status_i.busy);
  assign accept     = in_valid_i && in_ready_o;
  assign push       = accept && is_proc;

  assign load_o.we  = accept && !is_proc && (32'(entry_index_i) < MAX_DIRECTIONS);
  assign load_o.idx = entry_index_i;
  assign load_o.x   = dir_x_i;
  assign load_o.y   = dir_y_i;
  assign load_o.z   = dir_z_i;

  assign q_valid_o = (cnt_q != '0);
  assign q_resp_o  = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = status_i.pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(push) - CNT_W'(status_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= resp_i;
    end
  end

endmodule

>>> sv/smfr_back.sv
// Back end: direction table, steering pipeline, running maximum and output register.
module smfr_back #(
  parameter int MAX_DIRECTIONS = 512,
  parameter int SAMPLE_BITS    = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  smfr_pkg::load_req_t                 load_i,
  input  logic                                q_valid_i,
  input  smfr_pkg::resp_vec_t                 q_resp_i,
  output smfr_pkg::back_status_t              status_o,
  input  logic                                filter_mode_i,
  input  logic [smfr_pkg::COUNT_W-1:0]        direction_count_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [smfr_pkg::RESP_W-1:0]         max_response_o,
  output logic                                clipped_o
);
  import smfr_pkg::*;

  localparam int AW   = (MAX_DIRECTIONS > 1) ? $clog2(MAX_DIRECTIONS) : 1;
  localparam int CW   = $clog2(MAX_DIRECTIONS + 1);
  localparam int RW   = ACC_W - RND_SHIFT;
  localparam int ENTW = 3 * DIR_W;

  back_state_e state_q, state_d;
  logic        start, issue;

  resp_vec_t   resp_q;
  logic        mode_q;
  logic [CW-1:0] n_q, k_q;

  logic [ENTW-1:0] mem [MAX_DIRECTIONS];
  logic [ENTW-1:0] rdata_q;
  tag_t            tag_q [1:NUM_STAGES];
  tag_t            issue_tag;

  logic signed [PROD_W-1:0] p_q [NUM_TERMS];
  logic signed [31:0]       v_q [NUM_TERMS];
  logic signed [31:0]       v4_q [NUM_TERMS];
  logic [63:0]              div_q [NUM_TERMS];
  logic signed [ACC_W-1:0]  m_q [NUM_TERMS];
  logic signed [ACC_W-1:0]  a_q [3];
  logic signed [ACC_W-1:0]  s_q;
  logic signed [SAMPLE_BITS-1:0] r_q;
  logic                     rclip_q;

  logic signed [SAMPLE_BITS-1:0] best_q, best_new;
  logic                     clip_acc_q, clip_new;
  logic                     out_valid_q, out_clip_q;
  logic [RESP_W-1:0]        out_max_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (q_valid_i && !out_valid_q) state_d = ST_ISSUE;
      ST_ISSUE: if (k_q == n_q) state_d = ST_DRAIN;
      ST_DRAIN: if (tag_q[NUM_STAGES].valid && tag_q[NUM_STAGES].last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    start = 1'b0;
    issue = 1'b0;
    case (state_q)
      ST_IDLE:  start = q_valid_i && !out_valid_q;
      ST_ISSUE: issue = 1'b1;
      ST_DRAIN: ;
      default:  ;
    endcase
  end

  assign status_o.busy = (state_q != ST_IDLE);
  assign status_o.pop  = start;

  assign issue_tag.valid = issue;
  assign issue_tag.first = (k_q == '0);
  assign issue_tag.last  = (k_q == n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      for (int i = 1; i <= NUM_STAGES; i++) tag_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (start) k_q <= '0;
      else if (issue) k_q <= k_q + CW'(1);
      tag_q[1] <= issue_tag;
      for (int i = 2; i <= NUM_STAGES; i++) tag_q[i] <= tag_q[i-1];
    end
  end

  // Latch the voxel and clamp the count at start.
  always_ff @(posedge clk_i) begin
    if (start) begin
      resp_q <= q_resp_i;
      mode_q <= filter_mode_i;
      n_q    <= (32'(direction_count_i) > MAX_DIRECTIONS) ? CW'(MAX_DIRECTIONS)
                                                           : CW'(direction_count_i);
    end
  end

  // Direction table; slot k-1 feeds issue step k, step zero uses (1,0,0).
  always_ff @(posedge clk_i) begin
    if (load_i.we) mem[AW'(load_i.idx)] <= {load_i.x, load_i.y, load_i.z};
    rdata_q <= mem[AW'(k_q - CW'(1))];
  end

  // Stage 2: component products.
  logic signed [DIR_W-1:0] ux, uy, uz;
  always_comb begin
    ux = tag_q[1].first ? UNIT_X : $signed(rdata_q[3*DIR_W-1:2*DIR_W]);
    uy = tag_q[1].first ? '0     : $signed(rdata_q[2*DIR_W-1:DIR_W]);
    uz = tag_q[1].first ? '0     : $signed(rdata_q[DIR_W-1:0]);
  end

  always_ff @(posedge clk_i) begin
    p_q[0] <= ux * ux;
    p_q[1] <= uy * uy;
    p_q[2] <= uz * uz;
    p_q[3] <= ux * uy;
    p_q[4] <= ux * uz;
    p_q[5] <= uy * uz;
  end

  // Stage 3: walls give the weight directly, filaments leave a value to divide by three.
  logic signed [39:0] five_p [NUM_TERMS];
  logic signed [39:0] v_d [NUM_TERMS];
  always_comb begin
    for (int i = 0; i < NUM_TERMS; i++) begin
      five_p[i] = (40'(p_q[i]) <<< 2) + 40'(p_q[i]);
      if (i < 3) begin
        if (mode_q == MODE_FILAMENT)
          v_d[i] = ((40'sd3 <<< 32) - five_p[i] + 40'sd384) >>> 8;
        else
          v_d[i] = (five_p[i] - (40'sd1 <<< 32) + 40'sd512) >>> 10;
      end else begin
        if (mode_q == MODE_FILAMENT)
          v_d[i] = (five_p[i] + 40'sd192) >>> 7;
        else
          v_d[i] = (five_p[i] + 40'sd256) >>> 9;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_TERMS; i++) v_q[i] <= v_d[i][31:0];
  end

  // Stage 4: floor divide by three through a biased reciprocal multiply.
  logic [31:0] u_d [NUM_TERMS];
  always_comb begin
    for (int i = 0; i < NUM_TERMS; i++) u_d[i] = v_q[i] + DIV3_BIAS;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_TERMS; i++) begin
      div_q[i] <= 64'(u_d[i]) * 64'(DIV3_RECIP);
      v4_q[i]  <= v_q[i];
    end
  end

  // Stage 5: pick the weight and multiply by the basis response.
  logic signed [WGT_W-1:0] w [NUM_TERMS];
  always_comb begin
    for (int i = 0; i < NUM_TERMS; i++) begin
      if (mode_q == MODE_FILAMENT) w[i] = WGT_W'(32'(div_q[i] >> 33) - DIV3_UNBIAS);
      else                         w[i] = WGT_W'(v4_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_TERMS; i++) m_q[i] <= $signed(resp_q[i]) * w[i];
  end

  // Stages 6 and 7: adder tree.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) a_q[j] <= m_q[2*j] + m_q[2*j+1];
    s_q <= a_q[0] + a_q[1] + a_q[2];
  end

  // Stage 8: round to Q16.16, ties up, then saturate.
  logic signed [RW-1:0] rnd;
  logic signed [63:0]   rnd64, hi64, lo64;
  always_comb begin
    rnd   = RW'((s_q + (ACC_W'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT);
    rnd64 = 64'(rnd);
    hi64  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    lo64  = -hi64 - 64'sd1;
  end

  always_ff @(posedge clk_i) begin
    if (rnd64 > hi64)      r_q <= SAMPLE_BITS'(hi64);
    else if (rnd64 < lo64) r_q <= SAMPLE_BITS'(lo64);
    else                   r_q <= SAMPLE_BITS'(rnd64);
    rclip_q <= (rnd64 > hi64) || (rnd64 < lo64);
  end

  // Running maximum over the voxel's directions.
  always_comb begin
    if (tag_q[NUM_STAGES].first) begin
      best_new = r_q;
      clip_new = rclip_q;
    end else begin
      best_new = (r_q > best_q) ? r_q : best_q;
      clip_new = clip_acc_q || rclip_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_q[NUM_STAGES].valid) begin
      best_q     <= best_new;
      clip_acc_q <= clip_new;
    end
    if (tag_q[NUM_STAGES].valid && tag_q[NUM_STAGES].last) begin
      out_max_q  <= RESP_W'(64'(best_new));
      out_clip_q <= clip_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tag_q[NUM_STAGES].valid && tag_q[NUM_STAGES].last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign max_response_o = out_max_q;
  assign clipped_o      = out_clip_q;

endmodule

>>> sv/steerable_filter_max_response.sv
// Top level of the steerable second-derivative filter maximum-response block.
//
//  channel   direction  handshake                  payload
//  in        input      in_valid_i / in_ready_o    command, entry_index, dir_*, resp_*
//  out       output     out_valid_o / out_ready_i  max_response, clipped
//  cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A load writes the table port; it waits while voxels are queued or running.
// A voxel runs the steering pipeline over the unit x axis and then the n table directions (one
// direction per cycle through the shared multiply-accumulate bank, n the clamped direction count).
// The front queue holds two voxels, so input transfers continue while the back end works or
// while a result waits in the output register; a voxel starts only once that register is empty.
// Reset clears both registers, the queue and the sequencer; the table has no reset.
module steerable_filter_max_response #(
  parameter int MAX_DIRECTIONS = 512,
  parameter int SAMPLE_BITS    = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic [smfr_pkg::ENTRY_W-1:0]        entry_index_i,
  input  logic signed [smfr_pkg::DIR_W-1:0]   dir_x_i,
  input  logic signed [smfr_pkg::DIR_W-1:0]   dir_y_i,
  input  logic signed [smfr_pkg::DIR_W-1:0]   dir_z_i,
  input  logic signed [smfr_pkg::RESP_W-1:0]  resp_xx_i,
  input  logic signed [smfr_pkg::RESP_W-1:0]  resp_yy_i,
  input  logic signed [smfr_pkg::RESP_W-1:0]  resp_zz_i,
  input  logic signed [smfr_pkg::RESP_W-1:0]  resp_xy_i,
  input  logic signed [smfr_pkg::RESP_W-1:0]  resp_xz_i,
  input  logic signed [smfr_pkg::RESP_W-1:0]  resp_yz_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [smfr_pkg::RESP_W-1:0]  max_response_o,
  output logic                                clipped_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [smfr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [smfr_pkg::COUNT_W-1:0]        cfg_data_i
);
  import smfr_pkg::*;

  logic               filter_mode_q;
  logic [COUNT_W-1:0] direction_count_q;
  resp_vec_t          resp_in;
  resp_vec_t          q_resp;
  logic               q_valid;
  load_req_t          load_req;
  back_status_t       back_status;
  logic [RESP_W-1:0]  max_resp;

  // Configuration writes always complete; unknown indexes drop.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q     <= MODE_WALL;
      direction_count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FILTER_MODE:     filter_mode_q     <= cfg_data_i[0];
        REG_DIRECTION_COUNT: direction_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Basis responses in term order xx, yy, zz, xy, xz, yz.
  assign resp_in[0] = resp_xx_i;
  assign resp_in[1] = resp_yy_i;
  assign resp_in[2] = resp_zz_i;
  assign resp_in[3] = resp_xy_i;
  assign resp_in[4] = resp_xz_i;
  assign resp_in[5] = resp_yz_i;

  smfr_front #(
    .MAX_DIRECTIONS (MAX_DIRECTIONS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .entry_index_i (entry_index_i),
    .dir_x_i       (dir_x_i),
    .dir_y_i       (dir_y_i),
    .dir_z_i       (dir_z_i),
    .resp_i        (resp_in),
    .load_o        (load_req),
    .q_valid_o     (q_valid),
    .q_resp_o      (q_resp),
    .status_i      (back_status)
  );

  smfr_back #(
    .MAX_DIRECTIONS (MAX_DIRECTIONS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (load_req),
    .q_valid_i         (q_valid),
    .q_resp_i          (q_resp),
    .status_o          (back_status),
    .filter_mode_i     (filter_mode_q),
    .direction_count_i (direction_count_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .max_response_o    (max_resp),
    .clipped_o         (clipped_o)
  );

  assign max_response_o = $signed(max_resp);

endmodule

>>> sv/smfr_checker.sv
// Port-level checker for the steerable filter block and its bind.
`include "steerable_filter_max_response_assert.svh"

module smfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        command_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] max_response_o,
  input logic        clipped_o
);
  import smfr_pkg::*;

  logic [2:0] pending_q;
  logic       proc_xfer, out_xfer;

  assign proc_xfer = in_valid_i && in_ready_o && (command_i == CMD_PROCESS);
  assign out_xfer  = out_valid_o && out_ready_i;

  // Count voxels transferred in whose results have not been transferred out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(proc_xfer) - 3'(out_xfer);
    end
  end

  `SMFR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `SMFR_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(max_response_o) && $stable(clipped_o))
  `SMFR_ASSERT_SAME(a_no_phantom, clk_i, rst_ni, out_valid_o, pending_q != 3'd0)
  `SMFR_ASSERT_SAME(a_pending_max, clk_i, rst_ni, 1'b1, pending_q <= 3'd4)

endmodule

bind steerable_filter_max_response smfr_checker u_checker (.*);
